[rtl/byte_stream_content_classifier_assert.svh]
// Assertion macros for the byte stream content classifier.
// Needs signals named clk and rst in the module that uses them.
`ifndef BYTE_STREAM_CONTENT_CLASSIFIER_ASSERT_SVH
`define BYTE_STREAM_CONTENT_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS
`define BSCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bscc assertion failed");
`define BSCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bscc assertion failed");
`else
`define BSCC_ASSERT_IMP(lbl, ante, cons)
`define BSCC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/bscc_pkg.sv]
// Shared types and constants for the byte stream content classifier.
// No dependencies.
package bscc_pkg;

  localparam int COUNT_BITS   = 32;
  localparam int HEADER_DEPTH = 12;
  // 50 * count needs six more bits than count
  localparam int SCALED_BITS  = COUNT_BITS + 6;
  localparam logic [SCALED_BITS-1:0] CTRL_WEIGHT = SCALED_BITS'(50);
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX   = '1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  typedef logic [HEADER_DEPTH-1:0][7:0] hdr_t;

  typedef enum logic [3:0] {
    CLS_OCTET = 4'd0,
    CLS_PNG   = 4'd1,
    CLS_JPEG  = 4'd2,
    CLS_GIF   = 4'd3,
    CLS_PDF   = 4'd4,
    CLS_ZIP   = 4'd5,
    CLS_GZIP  = 4'd6,
    CLS_BMP   = 4'd7,
    CLS_ELF   = 4'd8,
    CLS_WEBP  = 4'd9,
    CLS_TEXT  = 4'd10
  } class_t;

endpackage

[rtl/bscc_sig_match.sv]
// Magic signature and byte order mark match over the buffer's first bytes.
// Depends on bscc_pkg.
module bscc_sig_match (
  input  bscc_pkg::hdr_t                    hdr,
  input  logic [bscc_pkg::COUNT_BITS-1:0]   count,
  output bscc_pkg::class_t                  sig_class
);
  import bscc_pkg::*;

  // signatures, first byte in the lowest bits
  localparam logic [63:0] SIG_PNG   = 64'h0A1A_0A0D_474E_5089;
  localparam logic [23:0] SIG_JPEG  = 24'hFF_D8FF;
  localparam logic [47:0] SIG_GIF7  = 48'h6137_3846_4947;
  localparam logic [47:0] SIG_GIF9  = 48'h6139_3846_4947;
  localparam logic [39:0] SIG_PDF   = 40'h2D_4644_5025;
  localparam logic [31:0] SIG_ZIP_A = 32'h0403_4B50;
  localparam logic [31:0] SIG_ZIP_B = 32'h0605_4B50;
  localparam logic [31:0] SIG_ZIP_C = 32'h0807_4B50;
  localparam logic [15:0] SIG_GZIP  = 16'h8B1F;
  localparam logic [15:0] SIG_BMP   = 16'h4D42;
  localparam logic [31:0] SIG_ELF   = 32'h464C_457F;
  localparam logic [31:0] SIG_RIFF  = 32'h4646_4952;
  localparam logic [31:0] SIG_WEBP  = 32'h5042_4557;
  localparam logic [15:0] BOM_LE16  = 16'hFEFF;
  localparam logic [15:0] BOM_BE16  = 16'hFFFE;
  localparam logic [23:0] BOM_UTF8  = 24'hBF_BBEF;

  logic ge2, ge3, ge4, ge5, ge6, ge8, ge12;

  assign ge2  = count >= COUNT_BITS'(2);
  assign ge3  = count >= COUNT_BITS'(3);
  assign ge4  = count >= COUNT_BITS'(4);
  assign ge5  = count >= COUNT_BITS'(5);
  assign ge6  = count >= COUNT_BITS'(6);
  assign ge8  = count >= COUNT_BITS'(8);
  assign ge12 = count >= COUNT_BITS'(12);

  always_comb begin
    if (ge8 && hdr[7:0] == SIG_PNG) begin
      sig_class = CLS_PNG;
    end else if (ge3 && hdr[2:0] == SIG_JPEG) begin
      sig_class = CLS_JPEG;
    end else if (ge6 && (hdr[5:0] == SIG_GIF7 || hdr[5:0] == SIG_GIF9)) begin
      sig_class = CLS_GIF;
    end else if (ge5 && hdr[4:0] == SIG_PDF) begin
      sig_class = CLS_PDF;
    end else if (ge4 && (hdr[3:0] == SIG_ZIP_A || hdr[3:0] == SIG_ZIP_B ||
                         hdr[3:0] == SIG_ZIP_C)) begin
      sig_class = CLS_ZIP;
    end else if (ge2 && hdr[1:0] == SIG_GZIP) begin
      sig_class = CLS_GZIP;
    end else if (ge2 && hdr[1:0] == SIG_BMP) begin
      sig_class = CLS_BMP;
    end else if (ge4 && hdr[3:0] == SIG_ELF) begin
      sig_class = CLS_ELF;
    end else if (ge12 && hdr[3:0] == SIG_RIFF && hdr[11:8] == SIG_WEBP) begin
      sig_class = CLS_WEBP;
    end else if (ge2 && (hdr[1:0] == BOM_LE16 || hdr[1:0] == BOM_BE16)) begin
      sig_class = CLS_TEXT;
    end else if (ge3 && hdr[2:0] == BOM_UTF8) begin
      sig_class = CLS_TEXT;
    end else begin
      sig_class = CLS_OCTET;
    end
  end

endmodule

[rtl/byte_stream_content_classifier.sv]
// The transfer that ends the buffer goes through the input register, then the result
// register. Throughput: one byte per cycle, sustained, since each byte only needs
// one pass of decode and count logic. The result register frees the input side while
// a result waits; the transfer ending the next buffer stalls until it is taken.
// Reset (rst, synchronous, active high) clears the valids and all buffer state.
// Depends on bscc_pkg, bscc_sig_match and byte_stream_content_classifier_assert.svh.
`include "byte_stream_content_classifier_assert.svh"

module byte_stream_content_classifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [bscc_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                                 s_tuser,   // [0] has_byte
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [bscc_pkg::OUT_TDATA_W-1:0]     m_tdata    // [3:0] content_class,
                                                          // [35:4] bytes_seen
);
  import bscc_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_has;
  logic       in_last;

  // buffer state
  hdr_t                   hdr, hdr_next;
  logic [COUNT_BITS-1:0]  byte_count, count_next;
  logic [COUNT_BITS-1:0]  control_char_count, ctrl_next;
  logic [SCALED_BITS-1:0] ctrl_scaled, scaled_next;  // 50 * control_char_count
  logic [1:0]             pending, pending_next;
  logic                   utf8_invalid, invalid_next;
  logic                   zero_seen, zero_next;

  // result register
  class_t                 class_q;
  logic [COUNT_BITS-1:0]  bytes_seen_q;

  logic   advance;
  logic   take;
  logic   is_ctrl;
  logic   text_ok;
  class_t sig_class;
  class_t class_next;

  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (take) begin
      in_byte <= s_tdata[7:0];
      in_has  <= s_tuser;
      in_last <= s_tlast;
    end
  end

  always_comb begin
    case (in_byte)
      8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D: is_ctrl = 1'b0;
      default:                           is_ctrl = in_byte < 8'h20;
    endcase
  end

  always_comb begin
    hdr_next     = hdr;
    count_next   = byte_count;
    ctrl_next    = control_char_count;
    scaled_next  = ctrl_scaled;
    pending_next = pending;
    invalid_next = utf8_invalid;
    zero_next    = zero_seen;
    if (in_has) begin
      for (int i = 0; i < HEADER_DEPTH; i++) begin
        if (byte_count == COUNT_BITS'(i)) begin
          hdr_next[i] = in_byte;
        end
      end
      if (byte_count != COUNT_MAX) begin
        count_next = byte_count + COUNT_BITS'(1);
      end
      if (in_byte == 8'h00) begin
        zero_next = 1'b1;
      end
      if (is_ctrl && control_char_count != COUNT_MAX) begin
        ctrl_next   = control_char_count + COUNT_BITS'(1);
        scaled_next = ctrl_scaled + CTRL_WEIGHT;
      end
      if (pending != 2'd0) begin
        if (in_byte[7:6] != 2'b10) begin
          invalid_next = 1'b1;
        end
        pending_next = pending - 2'd1;
      end else if (in_byte[7]) begin
        if (in_byte[7:5] == 3'b110) begin
          if (in_byte < 8'hC2) begin
            invalid_next = 1'b1;
          end else begin
            pending_next = 2'd1;
          end
        end else if (in_byte[7:4] == 4'b1110) begin
          pending_next = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
          if (in_byte > 8'hF4) begin
            invalid_next = 1'b1;
          end else begin
            pending_next = 2'd3;
          end
        end else begin
          invalid_next = 1'b1;
        end
      end
    end
  end

  bscc_sig_match u_sig_match (
    .hdr       (hdr_next),
    .count     (count_next),
    .sig_class (sig_class)
  );

  // ctrl <= count/50 is the same as 50*ctrl <= count
  assign text_ok = !invalid_next && pending_next == 2'd0 && !zero_next &&
                   (ctrl_next <= COUNT_BITS'(1) ||
                    scaled_next <= SCALED_BITS'(count_next));

  always_comb begin
    if (count_next == '0) begin
      class_next = CLS_OCTET;
    end else if (sig_class != CLS_OCTET) begin
      class_next = sig_class;
    end else if (text_ok) begin
      class_next = CLS_TEXT;
    end else begin
      class_next = CLS_OCTET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr                <= '0;
      byte_count         <= '0;
      control_char_count <= '0;
      ctrl_scaled        <= '0;
      pending            <= 2'd0;
      utf8_invalid       <= 1'b0;
      zero_seen          <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        hdr                <= '0;
        byte_count         <= '0;
        control_char_count <= '0;
        ctrl_scaled        <= '0;
        pending            <= 2'd0;
        utf8_invalid       <= 1'b0;
        zero_seen          <= 1'b0;
      end else begin
        hdr                <= hdr_next;
        byte_count         <= count_next;
        control_char_count <= ctrl_next;
        ctrl_scaled        <= scaled_next;
        pending            <= pending_next;
        utf8_invalid       <= invalid_next;
        zero_seen          <= zero_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && in_last) begin
      class_q      <= class_next;
      bytes_seen_q <= count_next;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - COUNT_BITS - 4)'(0), bytes_seen_q, class_q};

  `BSCC_ASSERT_NXT(a_clear_after_end, advance && in_last, byte_count == '0 && pending == 2'd0 && !utf8_invalid)
  `BSCC_ASSERT_NXT(a_result_loaded, advance && in_last, m_tvalid)
  `BSCC_ASSERT_IMP(a_ctrl_le_count, 1'b1, control_char_count <= byte_count)
  `BSCC_ASSERT_IMP(a_scaled_tracks, 1'b1, ctrl_scaled == SCALED_BITS'(control_char_count) * CTRL_WEIGHT)
  `BSCC_ASSERT_IMP(a_empty_octet, m_tvalid && bytes_seen_q == '0, class_q == CLS_OCTET)

endmodule

[verif/bscc_checker.sv]
// Scoreboard for the byte stream content classifier: watches both stream ports,
// predicts the content class and byte count of every buffer, and counts mismatches.
// Depends on bscc_pkg.
module bscc_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [bscc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
  input  logic                             s_tuser,   // [0] has_byte
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [bscc_pkg::OUT_TDATA_W-1:0] m_tdata,   // [3:0] content_class,
                                                      // [35:4] bytes_seen
  output int                               errors,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bscc_pkg::*;

  typedef struct {
    class_t            cls;
    logic [31:0]       nbytes;
  } verdict_t;

  verdict_t verdicts[$];

  // predicted buffer state
  hdr_t                  hdr;
  logic [COUNT_BITS-1:0] nbytes;
  logic [COUNT_BITS-1:0] nctrl;
  logic [1:0]            cont_due;
  logic                  bad_utf8;
  logic                  saw_zero;

  initial errors = 0;

  task automatic report(string msg);
    $display("bscc_checker: %s", msg);
    errors++;
  endtask

  task automatic clear_buffer();
    hdr      = '0;
    nbytes   = '0;
    nctrl    = '0;
    cont_due = '0;
    bad_utf8 = 1'b0;
    saw_zero = 1'b0;
  endtask

  task automatic absorb_byte(logic [7:0] b);
    if (nbytes < HEADER_DEPTH) hdr[nbytes] = b;
    if (nbytes != COUNT_MAX) nbytes++;
    if (b == 8'h00) saw_zero = 1'b1;
    if (b < 8'h20 && b != 8'h09 && b != 8'h0a && b != 8'h0c && b != 8'h0d && b != 8'h08) begin
      if (nctrl != COUNT_MAX) nctrl++;
    end
    if (cont_due != 2'd0) begin
      if (b[7:6] != 2'b10) bad_utf8 = 1'b1;
      cont_due = cont_due - 2'd1;
    end else if (b[7]) begin
      if (b[7:5] == 3'b110) begin
        if (b < 8'hc2) bad_utf8 = 1'b1;
        else cont_due = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cont_due = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        if (b > 8'hf4) bad_utf8 = 1'b1;
        else cont_due = 2'd3;
      end else begin
        bad_utf8 = 1'b1;
      end
    end
  endtask

  // sig holds the signature bytes, first byte in the low bits
  function automatic bit hdr_match(int off, int len, logic [63:0] sig);
    if (off + len > HEADER_DEPTH) return 1'b0;
    if (nbytes < off + len) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (hdr[off + k] != sig[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic class_t classify();
    logic [COUNT_BITS-1:0] limit;
    if (nbytes == 0) return CLS_OCTET;
    if (hdr_match(0, 8, 64'h0a1a0a0d474e5089)) return CLS_PNG;
    if (hdr_match(0, 3, 64'hffd8ff)) return CLS_JPEG;
    if (hdr_match(0, 6, 64'h613738464947) || hdr_match(0, 6, 64'h613938464947))
      return CLS_GIF;
    if (hdr_match(0, 5, 64'h2d46445025)) return CLS_PDF;
    if (hdr_match(0, 4, 64'h04034b50) || hdr_match(0, 4, 64'h06054b50) ||
        hdr_match(0, 4, 64'h08074b50))
      return CLS_ZIP;
    if (hdr_match(0, 2, 64'h8b1f)) return CLS_GZIP;
    if (hdr_match(0, 2, 64'h4d42)) return CLS_BMP;
    if (hdr_match(0, 4, 64'h464c457f)) return CLS_ELF;
    if (hdr_match(0, 4, 64'h46464952) && hdr_match(8, 4, 64'h50424557)) return CLS_WEBP;
    // byte order marks
    if (nbytes >= 2 && ((hdr[0] == 8'hff && hdr[1] == 8'hfe) ||
                        (hdr[0] == 8'hfe && hdr[1] == 8'hff)))
      return CLS_TEXT;
    if (nbytes >= 3 && hdr[0] == 8'hef && hdr[1] == 8'hbb && hdr[2] == 8'hbf)
      return CLS_TEXT;
    if (bad_utf8 || cont_due != 2'd0 || saw_zero) return CLS_OCTET;
    limit = nbytes / 50;
    if (limit == 0) limit = 1;
    return (nctrl <= limit) ? CLS_TEXT : CLS_OCTET;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    logic [3:0]  got_cls;
    logic [31:0] got_bytes;
    if (rst) begin
      clear_buffer();
      verdicts.delete();
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser) absorb_byte(s_tdata[7:0]);
        if (s_tlast) begin
          want.cls    = classify();
          want.nbytes = 32'(nbytes);
          verdicts.insert(verdicts.size(), want);
          clear_buffer();
        end
      end
      if (m_tvalid && m_tready) begin
        got_cls   = m_tdata[3:0];
        got_bytes = m_tdata[35:4];
        if (verdicts.size() == 0) begin
          report($sformatf("result with nothing pending: class %0d bytes %0d",
                           got_cls, got_bytes));
        end else begin
          want = verdicts.pop_front();
          if (got_cls != want.cls)
            report($sformatf("content_class got %0d want %0d (bytes %0d)",
                             got_cls, want.cls, want.nbytes));
          if (got_bytes != want.nbytes)
            report($sformatf("bytes_seen got %0d want %0d", got_bytes, want.nbytes));
        end
      end
      pending <= verdicts.size();
    end
  end

endmodule

[verif/tb.sv]
// Top of the classifier testbench: clock, reset, buffer stimulus, output stalls,
// watchdog and verdict. Depends on bscc_pkg, bscc_checker and the classifier RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1200;
  localparam int CALM_TAIL   = 200;   // items at the end sent with no idling
  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up

  localparam logic [63:0] SIG_PNG   = 64'h0a1a0a0d474e5089;
  localparam logic [63:0] SIG_JPEG  = 64'hffd8ff;
  localparam logic [63:0] SIG_GIF87 = 64'h613738464947;
  localparam logic [63:0] SIG_GIF89 = 64'h613938464947;
  localparam logic [63:0] SIG_PDF   = 64'h2d46445025;
  localparam logic [63:0] SIG_ZIP_A = 64'h04034b50;
  localparam logic [63:0] SIG_ZIP_B = 64'h06054b50;
  localparam logic [63:0] SIG_ZIP_C = 64'h08074b50;
  localparam logic [63:0] SIG_GZIP  = 64'h8b1f;
  localparam logic [63:0] SIG_BMP   = 64'h4d42;
  localparam logic [63:0] SIG_ELF   = 64'h464c457f;
  localparam logic [63:0] SIG_RIFF  = 64'h46464952;
  localparam logic [63:0] SIG_WEBP  = 64'h50424557;

  typedef enum int {
    S_PNG, S_JPEG, S_GIF, S_PDF, S_ZIP, S_GZIP, S_BMP, S_ELF, S_WEBP, S_BOM,
    S_TEXT, S_BROKEN, S_ZERO, S_NOISE
  } shape_t;

  logic                             clk      = 1'b0;
  logic                             rst      = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [bscc_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] data_byte
  logic                             s_tuser  = 1'b0; // [0] has_byte
  logic                             s_tlast  = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [bscc_pkg::OUT_TDATA_W-1:0] m_tdata;         // [3:0] content_class,
                                                     // [35:4] bytes_seen
  int   errors;
  int   pending;
  bit   idle_on    = 1'b1;
  int   items_sent = 0;
  int   stall_left = 0;
  int   quiet      = 0;
  logic [7:0] payload[$];

  byte_stream_content_classifier uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  bscc_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stall bursts on m_tready while idling is on
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // one transfer on the input side, with an occasional gap in front of it
  task automatic drive(logic [7:0] d, logic has, logic lst);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= has;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (has || lst) items_sent++;
  endtask

  // hold off the sender until every buffer so far has been classified
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_payload(bit empty_end);
    int n;
    n = payload.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) drive(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      drive(payload[i], 1'b1, (i == n - 1) && !empty_end);
    end
    if (empty_end || n == 0) drive(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // append one byte at the end of the payload
  task automatic append_byte(logic [7:0] b);
    payload.insert(payload.size(), b);
  endtask

  task automatic push_sig(int len, logic [63:0] sig);
    for (int k = 0; k < len; k++) append_byte(sig[8*k +: 8]);
  endtask

  task automatic push_random(int n);
    repeat (n) append_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_cont(int n);
    repeat (n) append_byte(8'($urandom_range(8'h80, 8'hbf)));
  endtask

  // n UTF-8 characters by lead and continuation byte pattern, ctrl_pct percent of them control bytes
  task automatic push_text(int n, int ctrl_pct);
    int r;
    logic [7:0] c;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < ctrl_pct) begin
        do c = 8'($urandom_range(1, 31));
        while (c == 8'h08 || c == 8'h09 || c == 8'h0a || c == 8'h0c || c == 8'h0d);
        append_byte(c);
      end else if (r < ctrl_pct + 8) begin
        case ($urandom_range(0, 4))
          0: append_byte(8'h08);
          1: append_byte(8'h09);
          2: append_byte(8'h0a);
          3: append_byte(8'h0c);
          default: append_byte(8'h0d);
        endcase
      end else if (r < 75) begin
        append_byte(8'($urandom_range(8'h20, 8'h7f)));
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            append_byte(8'($urandom_range(8'hc2, 8'hdf)));
            push_cont(1);
          end
          1: begin
            append_byte(8'($urandom_range(8'he0, 8'hef)));
            push_cont(2);
          end
          default: begin
            append_byte(8'($urandom_range(8'hf0, 8'hf4)));
            push_cont(3);
          end
        endcase
      end
    end
  endtask

  function automatic int text_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(50, 250) : $urandom_range(0, 30);
  endfunction

  function automatic int ctrl_mix();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      2: return 5;
      default: return 15;
    endcase
  endfunction

  task automatic build_payload();
    shape_t shape;
    int     cut;
    int     pos;
    payload.delete();
    shape = shape_t'($urandom_range(0, S_NOISE));
    case (shape)
      S_PNG:  push_sig(8, SIG_PNG);
      S_JPEG: push_sig(3, SIG_JPEG);
      S_GIF:  push_sig(6, $urandom_range(0, 1) ? SIG_GIF87 : SIG_GIF89);
      S_PDF:  push_sig(5, SIG_PDF);
      S_ZIP: begin
        case ($urandom_range(0, 2))
          0: push_sig(4, SIG_ZIP_A);
          1: push_sig(4, SIG_ZIP_B);
          default: push_sig(4, SIG_ZIP_C);
        endcase
      end
      S_GZIP: push_sig(2, SIG_GZIP);
      S_BMP:  push_sig(2, SIG_BMP);
      S_ELF:  push_sig(4, SIG_ELF);
      S_WEBP: begin
        push_sig(4, SIG_RIFF);
        push_random(4);
        push_sig(4, SIG_WEBP);
      end
      S_BOM: begin
        case ($urandom_range(0, 2))
          0: push_sig(2, 64'hfeff);
          1: push_sig(2, 64'hfffe);
          default: push_sig(3, 64'hbfbbef);
        endcase
      end
      S_TEXT: push_text(text_len(), ctrl_mix());
      S_BROKEN: begin
        push_text($urandom_range(0, 20), 2);
        case ($urandom_range(0, 2))
          0: begin
            // lead byte that UTF-8 never allows
            if ($urandom_range(0, 1)) append_byte(8'($urandom_range(8'h80, 8'hc1)));
            else append_byte(8'($urandom_range(8'hf5, 8'hff)));
            push_text($urandom_range(0, 10), 0);
          end
          1: begin
            // continuation due but a plain byte arrives
            append_byte(8'($urandom_range(8'hc2, 8'hf4)));
            append_byte(8'($urandom_range(8'h20, 8'h7f)));
            push_text($urandom_range(0, 10), 0);
          end
          default: begin
            // multibyte sequence cut off by the end of the buffer
            case ($urandom_range(0, 2))
              0: append_byte(8'($urandom_range(8'hc2, 8'hdf)));
              1: begin
                append_byte(8'($urandom_range(8'he0, 8'hef)));
                push_cont($urandom_range(0, 1));
              end
              default: begin
                append_byte(8'($urandom_range(8'hf0, 8'hf4)));
                push_cont($urandom_range(0, 2));
              end
            endcase
          end
        endcase
      end
      S_ZERO: begin
        push_text($urandom_range(0, 30), 0);
        pos = $urandom_range(0, payload.size());
        payload.insert(pos, 8'h00);
      end
      default: push_random($urandom_range(1, 40));
    endcase
    if (shape <= S_BOM) begin
      if ($urandom_range(0, 1)) push_text($urandom_range(0, 16), ctrl_mix());
      else push_random($urandom_range(0, 16));
      // damaged signature: one flipped bit, or the buffer cut back to a random length
      if ($urandom_range(0, 5) == 0) begin
        pos = $urandom_range(0, 3);
        if (pos < payload.size()) payload[pos] ^= 8'(1 << $urandom_range(0, 7));
      end else if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(0, payload.size());
        while (payload.size() > cut) void'(payload.pop_back());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed buffers
    drive(8'h3c, 1'b0, 1'b1);                    // empty buffer
    payload.delete(); push_sig(8, SIG_PNG);  send_payload(1'b0);
    payload.delete(); push_sig(3, SIG_JPEG); send_payload(1'b0);
    drive(8'ha5, 1'b0, 1'b0);                    // empty item, ignored
    drive(8'h00, 1'b1, 1'b1);                    // lone zero byte
    drive(8'hc2, 1'b1, 1'b1);                    // lead byte cut at the end
    drive(8'h41, 1'b1, 1'b0);
    drive(8'hff, 1'b0, 1'b1);                    // end marked by an empty item
    payload.delete(); push_sig(2, 64'hfffe); send_payload(1'b0);
    drive(8'h01, 1'b1, 1'b1);                    // one control char is tolerated
    drive(8'hff, 1'b1, 1'b1);                    // shorter than the JPEG mark
    drain();

    while (items_sent < ITEM_TARGET) begin
      idle_on <= (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      build_payload();
      send_payload($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 11) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
